[rtl/core/shps_pkg.sv]
// ----------------------------------------------------------------------------
// shps_pkg
// Types and constants shared by the script hash pattern scanner modules.
// ----------------------------------------------------------------------------
package shps_pkg;

  localparam int WIN_LEN    = 25;
  localparam int P2SH_LEN   = 23;
  localparam int HASH_WORDS = 5;
  localparam int FILL_W     = 5;

  localparam logic [7:0] OP_DUP         = 8'h76;
  localparam logic [7:0] OP_HASH160     = 8'ha9;
  localparam logic [7:0] OP_PUSH20      = 8'h14;
  localparam logic [7:0] OP_EQUALVERIFY = 8'h88;
  localparam logic [7:0] OP_CHECKSIG    = 8'hac;
  localparam logic [7:0] OP_EQUAL       = 8'h87;

  // request kinds carried in tuser
  localparam logic REQ_KEY_LOAD = 1'b0;
  localparam logic REQ_SCAN     = 1'b1;

  typedef logic [HASH_WORDS-1:0][31:0] hash_t;

  typedef enum logic {
    SRCH_IDLE,
    SRCH_RUN
  } srch_state_t;

  // script found on the incoming byte
  typedef struct packed {
    logic found;
    logic p2sh;
  } cand_t;

  // key store word write
  typedef struct packed {
    logic        en;
    logic [5:0]  slot;
    logic [2:0]  widx;
    logic [31:0] value;
  } key_wr_t;

  // key search status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
    logic armed;
  } srch_stat_t;

endpackage

[rtl/core/shps_cell.sv]
// ----------------------------------------------------------------------------
// shps_cell
// One byte cell of the sliding window; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module shps_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  logic [7:0] q;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      q <= '0;
    end else if (shift) begin
      q <= din;
    end
  end

  assign dout = q;

endmodule

[rtl/core/shps_window.sv]
// ----------------------------------------------------------------------------
// shps_window
// Row of 25 byte cells with fill count, script pattern detect and hash select.
// ----------------------------------------------------------------------------
module shps_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic                 clear,
  input  logic [7:0]           data_byte,
  output shps_pkg::cand_t      cand,
  output shps_pkg::hash_t      hash
);

  import shps_pkg::*;

  logic [7:0]        win [WIN_LEN];
  logic [7:0]        nxt [WIN_LEN];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              p2sh;
  logic              hit_pkh;
  logic              hit_sh;

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    if (i == WIN_LEN - 1) begin : g_tail
      assign nxt[i] = data_byte;
    end else begin : g_body
      assign nxt[i] = win[i+1];
    end
    shps_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .clear (clear),
      .din   (nxt[i]),
      .dout  (win[i])
    );
  end

  assign fill_next = (fill == FILL_W'(WIN_LEN)) ? fill : fill + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
    end else if (shift) begin
      fill <= fill_next;
    end
  end

  // patterns are judged on the window as it stands after this byte
  assign hit_pkh = (fill_next >= FILL_W'(WIN_LEN)) &&
                   (nxt[0] == OP_DUP) && (nxt[1] == OP_HASH160) &&
                   (nxt[2] == OP_PUSH20) && (nxt[WIN_LEN-2] == OP_EQUALVERIFY) &&
                   (nxt[WIN_LEN-1] == OP_CHECKSIG);
  assign hit_sh  = (fill_next >= FILL_W'(P2SH_LEN)) &&
                   (nxt[WIN_LEN-P2SH_LEN] == OP_HASH160) &&
                   (nxt[WIN_LEN-P2SH_LEN+1] == OP_PUSH20) &&
                   (nxt[WIN_LEN-1] == OP_EQUAL);

  assign cand.found = hit_pkh || hit_sh;
  assign cand.p2sh  = hit_sh;

  // remember which script so the hash offset is right during the search
  always_ff @(posedge clk) begin
    if (rst) begin
      p2sh <= 1'b0;
    end else if (shift && cand.found) begin
      p2sh <= hit_sh;
    end
  end

  always_comb begin
    for (int w = 0; w < HASH_WORDS; w++) begin
      if (p2sh) begin
        hash[w] = {win[4+4*w], win[5+4*w], win[6+4*w], win[7+4*w]};
      end else begin
        hash[w] = {win[3+4*w], win[4+4*w], win[5+4*w], win[6+4*w]};
      end
    end
  end

endmodule

[rtl/core/shps_key_search.sv]
// ----------------------------------------------------------------------------
// shps_key_search
// Key store memory and sequencer that compares one slot per cycle to a hash.
// ----------------------------------------------------------------------------
module shps_key_search #(
  parameter int KEY_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  shps_pkg::key_wr_t    kw,
  input  logic [6:0]           keys_in_use,
  input  shps_pkg::hash_t      hash,
  output shps_pkg::srch_stat_t stat
);

  import shps_pkg::*;

  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W  = $clog2(KEY_SLOTS + 1);

  hash_t             key_mem [KEY_SLOTS];
  hash_t             rd_data;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_addr;
  logic [31:0]       slot_ext;
  logic [31:0]       keys_ext;
  logic [31:0]       lim_ext;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              cmp_valid;
  logic              cmp_valid_next;
  logic              issue;
  logic              hit;
  logic              done;
  logic              wr_ok;
  srch_state_t       state;
  srch_state_t       state_next;

  assign keys_ext = 32'(keys_in_use);
  assign lim_ext  = (keys_ext > 32'(KEY_SLOTS)) ? 32'(KEY_SLOTS) : keys_ext;
  assign lim      = lim_ext[CNT_W-1:0];

  assign slot_ext = 32'(kw.slot);
  assign wr_addr  = slot_ext[SLOT_W-1:0];
  assign wr_ok    = kw.en && (kw.widx < 3'(HASH_WORDS)) && (slot_ext < 32'(KEY_SLOTS));
  assign rd_addr  = cnt[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      key_mem[wr_addr][kw.widx] <= kw.value;
    end
    rd_data <= key_mem[rd_addr];
  end

  assign hit = cmp_valid && (rd_data == hash);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SRCH_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmp_valid_next = 1'b0;
    issue          = 1'b0;
    done           = 1'b0;
    case (state)
      SRCH_IDLE: begin
        cnt_next = '0;
        if (start) begin
          state_next = SRCH_RUN;
        end
      end
      SRCH_RUN: begin
        issue = (cnt < lim);
        if (hit || (!issue && !cmp_valid)) begin
          done       = 1'b1;
          state_next = SRCH_IDLE;
          cnt_next   = '0;
        end else begin
          cmp_valid_next = issue;
          if (issue) begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = SRCH_IDLE;
      end
    endcase
  end

  assign stat.busy  = (state == SRCH_RUN);
  assign stat.done  = done;
  assign stat.hit   = hit;
  assign stat.armed = (lim != '0);

endmodule

[rtl/core/script_hash_pattern_scanner_top.sv]
// A byte with no script ending on it does not hold off input; a file result is in
// the output register the cycle after its last byte, or after the key search
// that byte starts. A completed script, if keys_in_use is nonzero, starts a
// search of one slot per cycle over up to min(keys_in_use, KEY_SLOTS) slots,
// ending early on a hit, with input held off until the search ends.
// Reset (rst, synchronous) clears window, fill, flag, keys_in_use and output.
// ----------------------------------------------------------------------------
// script_hash_pattern_scanner_top
// Scans file bytes for P2PKH and P2SH scripts and looks up their hashes.
// ----------------------------------------------------------------------------
module script_hash_pattern_scanner_top #(
  parameter int KEY_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,   // keys_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,     // key_slot, word_index, word_value, data_byte, zero pad
  input  logic [0:0]  s_tuser,     // req_type
  input  logic        s_tlast,     // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata      // file_match, zero pad
);

  import shps_pkg::*;

  logic [6:0]  keys_in_use;
  logic        acc;
  logic        scan;
  logic        start;
  logic        win_clear;
  logic        short_end;
  logic        pend_last;
  logic        match_seen;
  logic        out_bit;
  cand_t       cand;
  hash_t       hash;
  key_wr_t     kw;
  srch_stat_t  stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_in_use <= '0;
    end else if (cfg_we) begin
      keys_in_use <= cfg_wdata;
    end
  end

  assign s_tready  = !stat.busy && (!m_tvalid || m_tready);
  assign acc       = s_tvalid && s_tready;
  assign scan      = acc && (s_tuser[0] == REQ_SCAN);
  assign start     = scan && cand.found && stat.armed;
  // last word with no search to wait for closes the file at once
  assign short_end = scan && s_tlast && !start;
  assign win_clear = short_end || (stat.done && pend_last);

  assign kw.en    = acc && (s_tuser[0] == REQ_KEY_LOAD);
  assign kw.slot  = s_tdata[5:0];
  assign kw.widx  = s_tdata[8:6];
  assign kw.value = s_tdata[40:9];

  shps_window u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (scan),
    .clear     (win_clear),
    .data_byte (s_tdata[48:41]),
    .cand      (cand),
    .hash      (hash)
  );

  shps_key_search #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .kw          (kw),
    .keys_in_use (keys_in_use),
    .hash        (hash),
    .stat        (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_last <= 1'b0;
    end else if (start) begin
      pend_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || win_clear) begin
      match_seen <= 1'b0;
    end else if (stat.done && stat.hit) begin
      match_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (win_clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win_clear) begin
      out_bit <= match_seen || (stat.done && stat.hit);
    end
  end

  assign m_tdata = {7'b0, out_bit};

endmodule

[rtl/core/shps_checker.sv]
// ----------------------------------------------------------------------------
// shps_checker
// Port-level checks on the scanner, bound to the top level.
// ----------------------------------------------------------------------------
module shps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  import shps_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // no input taken while a result waits and is not taken
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while result stalled");

  // a key word never makes a result
  a_key_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == REQ_KEY_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("result after key load");

  // result word only carries the flag bit
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] == 7'b0))
    else $error("result padding not zero");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind script_hash_pattern_scanner_top shps_checker u_shps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
